### rtl/core/ucs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucs_pkg
// Shared constants and types for the URI component splitter: character codes,
// component codes, field widths and the record set handed from parser to
// emitter.
// ----------------------------------------------------------------------------
package ucs_pkg;

  localparam int MAX_LEN_DEF = 4096;

  localparam int CH_W     = 8;
  localparam int OFS_W    = 13;
  localparam int PORT_W   = 16;
  localparam int ACC_W    = 17;
  localparam int DIGIT_W  = 3;
  localparam int NUM_COMP = 7;

  localparam logic [DIGIT_W-1:0] PORT_MAX_DIGITS = 3'd5;

  localparam logic [CH_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CH_W-1:0] CH_QUEST = 8'h3F;
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CH_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    COMP_SCHEME   = 3'd0,
    COMP_HOST     = 3'd1,
    COMP_PORT     = 3'd2,
    COMP_PATH     = 3'd3,
    COMP_QUERY    = 3'd4,
    COMP_FRAGMENT = 3'd5,
    COMP_CLOSE    = 3'd6
  } ucs_comp_t;

  // Everything needed to emit the records of one finished string.
  typedef struct packed {
    logic [NUM_COMP-1:0] mask;
    logic [OFS_W-1:0]    scheme_len;
    logic [OFS_W-1:0]    host_start;
    logic [OFS_W-1:0]    host_len;
    logic [OFS_W-1:0]    port_start;
    logic [OFS_W-1:0]    port_len;
    logic [PORT_W-1:0]   port_value;
    logic [OFS_W-1:0]    path_start;
    logic [OFS_W-1:0]    path_len;
    logic [OFS_W-1:0]    query_start;
    logic [OFS_W-1:0]    query_len;
    logic [OFS_W-1:0]    frag_start;
    logic [OFS_W-1:0]    frag_len;
    logic [OFS_W-1:0]    total_len;
    logic                abs_flag;
    logic                frag_only_flag;
    logic                overflow;
  } ucs_snap_t;

  function automatic logic is_alpha(input logic [CH_W-1:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_scheme_char(input logic [CH_W-1:0] c);
    return is_alpha(c) || is_digit(c) || c == CH_PLUS || c == CH_MINUS || c == CH_DOT;
  endfunction

endpackage

### rtl/core/ucs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucs_if
// Valid/ready channels of the URI component splitter: the byte stream in and
// the component records out.
// ----------------------------------------------------------------------------
interface ucs_in_if import ucs_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            end_of_uri;

  modport source (output valid, ch, end_of_uri, input ready);
  modport sink (input valid, ch, end_of_uri, output ready);
endinterface

interface ucs_out_if import ucs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        component;
  logic [OFS_W-1:0]  start_offset;
  logic [OFS_W-1:0]  length;
  logic [PORT_W-1:0] port_value;
  logic              abs_flag;
  logic              frag_only_flag;
  logic              overflow;
  logic              last;

  modport source (output valid, component, start_offset, length, port_value,
                  abs_flag, frag_only_flag, overflow, last, input ready);
  modport sink (input valid, component, start_offset, length, port_value,
                abs_flag, frag_only_flag, overflow, last, output ready);
endinterface

### rtl/core/uri_component_splitter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uri_component_splitter_top
// Splits a URI reference, streamed one byte per transfer, into scheme, host,
// port, path, query and fragment records, followed by a closing record.
// ----------------------------------------------------------------------------
// Bytes are taken at one per clock with no gaps; the parse state is updated
// in the same cycle. The end item hands the component set to a record
// register bank, which sends one record per cycle unless the output side
// stalls (one to seven records per string) while bytes of the next string keep
// flowing in. An end item waits while the previous string still has records
// other than its closing record left to send, or while that closing record
// cannot yet move into the output register. Bytes past MAX_LEN are dropped
// and flag overflow on every record of that string.
// ----------------------------------------------------------------------------
module uri_component_splitter_top import ucs_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ucs_in_if.sink    uri,
  ucs_out_if.source rec
);

  ucs_snap_t snap;
  logic      free;
  logic      take;

  assign uri.ready = free || !uri.end_of_uri;
  assign take      = uri.valid && uri.ready;

  ucs_parser #(
    .MAX_LEN (MAX_LEN)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .ch         (uri.ch),
    .end_of_uri (uri.end_of_uri),
    .snap       (snap)
  );

  ucs_emit u_emit (
    .clk     (clk),
    .rst     (rst),
    .load    (take && uri.end_of_uri),
    .snap_in (snap),
    .free    (free),
    .rec     (rec)
  );

endmodule

### rtl/core/ucs_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucs_parser
// Per-byte parse state of the URI reference. On the end item it presents the
// finished component set and returns to the start-of-string state.
// ----------------------------------------------------------------------------
module ucs_parser import ucs_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [CH_W-1:0] ch,
  input  logic            end_of_uri,
  output ucs_snap_t       snap
);

  localparam int PW = $clog2(MAX_LEN + 1);
  localparam logic [PW-1:0] MAX_POS = PW'(MAX_LEN);

  typedef enum logic [2:0] {
    M_START, M_SCHEME, M_AT_P, M_SLASH1, M_AUTH, M_PATH, M_QUERY, M_FRAG
  } mode_t;

  mode_t                mode, mode_next;
  logic [PW-1:0]        position, position_next;
  logic [PW-1:0]        scheme_length, scheme_length_next;
  logic                 absolute, absolute_next;
  logic                 frag_only, frag_only_next;
  logic [PW-1:0]        part_start, part_start_next;
  logic [PW-1:0]        host_begin, host_begin_next;
  logic [PW-1:0]        last_colon, last_colon_next;
  logic                 colon_seen, colon_seen_next;
  logic [PW-1:0]        authority_end, authority_end_next;
  logic [PW-1:0]        path_begin, path_begin_next;
  logic [PW-1:0]        path_len, path_len_next;
  logic [PW-1:0]        query_begin, query_begin_next;
  logic [PW-1:0]        query_len, query_len_next;
  logic [PW-1:0]        frag_begin, frag_begin_next;
  logic                 has_host, has_host_next;
  logic                 has_path, has_path_next;
  logic                 has_query, has_query_next;
  logic                 has_frag, has_frag_next;
  logic [ACC_W-1:0]     port_accum, port_accum_next;
  logic [DIGIT_W-1:0]   port_digits, port_digits_next;
  logic                 port_bad, port_bad_next;
  logic                 overflow, overflow_next;

  logic          do_at_p, do_begin_path, do_path_char;
  logic [PW-1:0] bp_at, pos_p1;

  assign pos_p1 = position + PW'(1);

  always_comb begin
    mode_next          = mode;
    position_next      = position;
    scheme_length_next = scheme_length;
    absolute_next      = absolute;
    frag_only_next     = frag_only;
    part_start_next    = part_start;
    host_begin_next    = host_begin;
    last_colon_next    = last_colon;
    colon_seen_next    = colon_seen;
    authority_end_next = authority_end;
    path_begin_next    = path_begin;
    path_len_next      = path_len;
    query_begin_next   = query_begin;
    query_len_next     = query_len;
    frag_begin_next    = frag_begin;
    has_host_next      = has_host;
    has_path_next      = has_path;
    has_query_next     = has_query;
    has_frag_next      = has_frag;
    port_accum_next    = port_accum;
    port_digits_next   = port_digits;
    port_bad_next      = port_bad;
    overflow_next      = overflow;
    do_at_p            = 1'b0;
    do_begin_path      = 1'b0;
    do_path_char       = 1'b0;
    bp_at              = position;

    if (take && end_of_uri) begin
      mode_next          = M_START;
      position_next      = '0;
      scheme_length_next = '0;
      absolute_next      = 1'b0;
      frag_only_next     = 1'b0;
      part_start_next    = '0;
      host_begin_next    = '0;
      last_colon_next    = '0;
      colon_seen_next    = 1'b0;
      authority_end_next = '0;
      path_begin_next    = '0;
      path_len_next      = '0;
      query_begin_next   = '0;
      query_len_next     = '0;
      frag_begin_next    = '0;
      has_host_next      = 1'b0;
      has_path_next      = 1'b0;
      has_query_next     = 1'b0;
      has_frag_next      = 1'b0;
      port_accum_next    = '0;
      port_digits_next   = '0;
      port_bad_next      = 1'b0;
      overflow_next      = 1'b0;
    end else if (take && position >= MAX_POS) begin
      overflow_next = 1'b1;
    end else if (take) begin
      position_next = pos_p1;
      unique case (mode)
        M_START: begin
          if (ch == CH_HASH) begin
            frag_only_next  = 1'b1;
            frag_begin_next = PW'(1);
            has_frag_next   = 1'b1;
            mode_next       = M_FRAG;
          end else if (is_alpha(ch)) begin
            mode_next = M_SCHEME;
          end else begin
            do_at_p = 1'b1;
          end
        end
        M_SCHEME: begin
          if (ch == CH_COLON) begin
            absolute_next      = 1'b1;
            scheme_length_next = position;
            mode_next          = M_AT_P;
          end else if (!is_scheme_char(ch)) begin
            do_begin_path = 1'b1;
            bp_at         = '0;
            do_path_char  = 1'b1;
          end
        end
        M_AT_P: do_at_p = 1'b1;
        M_SLASH1: begin
          if (ch == CH_SLASH) begin
            host_begin_next = pos_p1;
            has_host_next   = 1'b1;
            mode_next       = M_AUTH;
          end else begin
            do_begin_path = 1'b1;
            bp_at         = part_start;
            do_path_char  = 1'b1;
          end
        end
        M_AUTH: begin
          if (ch == CH_SLASH || ch == CH_QUEST || ch == CH_HASH) begin
            authority_end_next = position;
            do_at_p            = 1'b1;
            // A slash ending the authority is the first byte of the path.
            do_begin_path      = (ch == CH_SLASH);
          end else if (ch == CH_COLON) begin
            colon_seen_next  = 1'b1;
            last_colon_next  = position;
            port_accum_next  = '0;
            port_digits_next = '0;
            port_bad_next    = 1'b0;
          end else if (colon_seen) begin
            if (!is_digit(ch) || port_digits >= PORT_MAX_DIGITS) begin
              port_bad_next = 1'b1;
            end else begin
              port_accum_next  = ACC_W'(port_accum * ACC_W'(10))
                                 + {{(ACC_W-4){1'b0}}, ch[3:0]};
              port_digits_next = port_digits + DIGIT_W'(1);
            end
          end
        end
        M_PATH: do_path_char = 1'b1;
        M_QUERY: begin
          if (ch == CH_HASH) begin
            query_len_next  = position - query_begin;
            frag_begin_next = pos_p1;
            has_frag_next   = 1'b1;
            mode_next       = M_FRAG;
          end
        end
        M_FRAG: ;
        default: ;
      endcase

      if (do_at_p) begin
        if (ch == CH_SLASH) begin
          part_start_next = position;
          mode_next       = M_SLASH1;
        end else if (ch == CH_QUEST) begin
          query_begin_next = pos_p1;
          has_query_next   = 1'b1;
          mode_next        = M_QUERY;
        end else if (ch == CH_HASH) begin
          frag_begin_next = pos_p1;
          has_frag_next   = 1'b1;
          mode_next       = M_FRAG;
        end else begin
          path_begin_next = position;
          has_path_next   = 1'b1;
          mode_next       = M_PATH;
        end
      end

      if (do_begin_path) begin
        path_begin_next = bp_at;
        has_path_next   = 1'b1;
        mode_next       = M_PATH;
      end

      if (do_path_char) begin
        if (ch == CH_QUEST) begin
          path_len_next    = position - path_begin_next;
          query_begin_next = pos_p1;
          has_query_next   = 1'b1;
          mode_next        = M_QUERY;
        end else if (ch == CH_HASH) begin
          path_len_next   = position - path_begin_next;
          frag_begin_next = pos_p1;
          has_frag_next   = 1'b1;
          mode_next       = M_FRAG;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_START;
      position      <= '0;
      scheme_length <= '0;
      absolute      <= 1'b0;
      frag_only     <= 1'b0;
      part_start    <= '0;
      host_begin    <= '0;
      last_colon    <= '0;
      colon_seen    <= 1'b0;
      authority_end <= '0;
      path_begin    <= '0;
      path_len      <= '0;
      query_begin   <= '0;
      query_len     <= '0;
      frag_begin    <= '0;
      has_host      <= 1'b0;
      has_path      <= 1'b0;
      has_query     <= 1'b0;
      has_frag      <= 1'b0;
      port_accum    <= '0;
      port_digits   <= '0;
      port_bad      <= 1'b0;
      overflow      <= 1'b0;
    end else begin
      mode          <= mode_next;
      position      <= position_next;
      scheme_length <= scheme_length_next;
      absolute      <= absolute_next;
      frag_only     <= frag_only_next;
      part_start    <= part_start_next;
      host_begin    <= host_begin_next;
      last_colon    <= last_colon_next;
      colon_seen    <= colon_seen_next;
      authority_end <= authority_end_next;
      path_begin    <= path_begin_next;
      path_len      <= path_len_next;
      query_begin   <= query_begin_next;
      query_len     <= query_len_next;
      frag_begin    <= frag_begin_next;
      has_host      <= has_host_next;
      has_path      <= has_path_next;
      has_query     <= has_query_next;
      has_frag      <= has_frag_next;
      port_accum    <= port_accum_next;
      port_digits   <= port_digits_next;
      port_bad      <= port_bad_next;
      overflow      <= overflow_next;
    end
  end

  // Close whatever part is still open and form the record set.
  logic [PW-1:0] auth_stop_f, host_end_f, path_begin_f, path_len_f, query_len_f;
  logic          has_path_f;

  always_comb begin
    auth_stop_f  = (mode == M_AUTH) ? position : authority_end;
    host_end_f   = colon_seen ? last_colon : auth_stop_f;
    path_begin_f = path_begin;
    path_len_f   = path_len;
    has_path_f   = has_path;
    case (mode)
      M_SCHEME: begin
        path_begin_f = '0;
        path_len_f   = position;
        has_path_f   = 1'b1;
      end
      M_SLASH1: begin
        path_begin_f = part_start;
        path_len_f   = position - part_start;
        has_path_f   = 1'b1;
      end
      M_PATH: path_len_f = position - path_begin;
      default: ;
    endcase
    query_len_f = (mode == M_QUERY) ? position - query_begin : query_len;

    snap.mask = {1'b1, has_frag, has_query, has_path_f, has_host & colon_seen,
                 has_host, absolute};
    snap.scheme_len  = OFS_W'(scheme_length);
    snap.host_start  = OFS_W'(host_begin);
    snap.host_len    = OFS_W'(host_end_f - host_begin);
    snap.port_start  = OFS_W'(last_colon + PW'(1));
    snap.port_len    = OFS_W'(auth_stop_f - last_colon - PW'(1));
    snap.port_value  = (!port_bad && port_digits != '0 && !port_accum[ACC_W-1])
                       ? port_accum[PORT_W-1:0] : '0;
    snap.path_start  = OFS_W'(path_begin_f);
    snap.path_len    = OFS_W'(path_len_f);
    snap.query_start = OFS_W'(query_begin);
    snap.query_len   = OFS_W'(query_len_f);
    snap.frag_start  = OFS_W'(frag_begin);
    snap.frag_len    = OFS_W'(position - frag_begin);
    snap.total_len   = OFS_W'(position);
    snap.abs_flag       = absolute;
    snap.frag_only_flag = frag_only;
    snap.overflow       = overflow;
  end

endmodule

### rtl/core/ucs_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucs_emit
// Holds the record set of one finished string and sends its records, one per
// cycle unless the output side stalls, through an output register.
// ----------------------------------------------------------------------------
module ucs_emit import ucs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  ucs_snap_t  snap_in,
  output logic       free,
  ucs_out_if.source  rec
);

  localparam logic [NUM_COMP-1:0] CLOSE_ONLY = NUM_COMP'(1) << COMP_CLOSE;

  ucs_snap_t           snap;
  logic [NUM_COMP-1:0] pending, pending_next;
  logic [NUM_COMP-1:0] sel;
  logic                out_valid;
  logic                advance;
  ucs_comp_t           sel_comp;

  // Lowest pending component goes next.
  always_comb begin
    sel      = '0;
    sel_comp = COMP_CLOSE;
    for (int i = NUM_COMP - 1; i >= 0; i--) begin
      if (pending[i]) begin
        sel      = NUM_COMP'(1) << i;
        sel_comp = ucs_comp_t'(3'(i));
      end
    end
  end

  assign advance = (pending != '0) && (!out_valid || rec.ready);
  // A new set may come in during the cycle that sends the closing record.
  assign free    = (pending == '0) || (pending == CLOSE_ONLY && advance);

  always_comb begin
    pending_next = advance ? (pending & ~sel) : pending;
    if (load) begin
      pending_next = snap_in.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      out_valid <= 1'b0;
    end else begin
      pending <= pending_next;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (rec.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      snap <= snap_in;
    end
    if (advance) begin
      rec.component      <= sel_comp;
      rec.port_value     <= '0;
      rec.abs_flag       <= snap.abs_flag;
      rec.frag_only_flag <= snap.frag_only_flag;
      rec.overflow       <= snap.overflow;
      rec.last           <= 1'b0;
      case (sel_comp)
        COMP_SCHEME: begin
          rec.start_offset <= '0;
          rec.length       <= snap.scheme_len;
        end
        COMP_HOST: begin
          rec.start_offset <= snap.host_start;
          rec.length       <= snap.host_len;
        end
        COMP_PORT: begin
          rec.start_offset <= snap.port_start;
          rec.length       <= snap.port_len;
          rec.port_value   <= snap.port_value;
        end
        COMP_PATH: begin
          rec.start_offset <= snap.path_start;
          rec.length       <= snap.path_len;
        end
        COMP_QUERY: begin
          rec.start_offset <= snap.query_start;
          rec.length       <= snap.query_len;
        end
        COMP_FRAGMENT: begin
          rec.start_offset <= snap.frag_start;
          rec.length       <= snap.frag_len;
        end
        default: begin
          rec.start_offset <= '0;
          rec.length       <= snap.total_len;
          rec.last         <= 1'b1;
        end
      endcase
    end
  end

  assign rec.valid = out_valid;

endmodule

### dv/ucs_record_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucs_record_checker
// Watches both channels of the URI component splitter. Every byte transfer
// updates a local copy of the parse state. Every end transfer turns that
// state into the expected component records. Each record transfer is then
// compared against the oldest expected record.
// ----------------------------------------------------------------------------
module ucs_record_checker import ucs_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic clk,
  input  logic rst,
  ucs_in_if    in_ch,
  ucs_out_if   out_ch,
  output int   fail_count,
  output int   pending
);

  localparam int SHOW_LIMIT = 10;

  typedef enum logic [3:0] {
    PM_START,
    PM_SCHEME,
    PM_AFTER_SCHEME,
    PM_SLASH1,
    PM_AUTH,
    PM_PATH,
    PM_QUERY,
    PM_FRAG
  } parse_mode_t;

  typedef struct packed {
    ucs_comp_t         comp;
    logic [OFS_W-1:0]  start;
    logic [OFS_W-1:0]  len;
    logic [PORT_W-1:0] port;
    logic              absolute;
    logic              frag_only;
    logic              ovf;
    logic              last;
  } record_t;

  parse_mode_t        mode;
  logic [OFS_W-1:0]   pos, scheme_len, seg_start, host_start, colon_pos, authority_stop;
  logic [OFS_W-1:0]   path_start, path_len, query_start, query_len, frag_start;
  logic               absolute, frag_only, colon_seen, port_bad, overflowed;
  logic               has_host, has_path, has_query, has_frag;
  logic [ACC_W-1:0]   port_acc;
  logic [DIGIT_W-1:0] port_ndig;
  record_t            recs_due[$];
  int                 shown;

  function automatic logic letter_byte(input logic [CH_W-1:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic scheme_byte(input logic [CH_W-1:0] c);
    return letter_byte(c) || (c >= CH_ZERO && c <= CH_NINE) ||
           c == CH_PLUS || c == CH_MINUS || c == CH_DOT;
  endfunction

  function automatic void clear_parse();
    mode           = PM_START;
    pos            = '0;
    scheme_len     = '0;
    seg_start      = '0;
    host_start     = '0;
    colon_pos      = '0;
    authority_stop = '0;
    path_start     = '0;
    path_len       = '0;
    query_start    = '0;
    query_len      = '0;
    frag_start     = '0;
    absolute       = 1'b0;
    frag_only      = 1'b0;
    colon_seen     = 1'b0;
    port_bad       = 1'b0;
    overflowed     = 1'b0;
    has_host       = 1'b0;
    has_path       = 1'b0;
    has_query      = 1'b0;
    has_frag       = 1'b0;
    port_acc       = '0;
    port_ndig      = '0;
  endfunction

  function automatic void open_path(input logic [OFS_W-1:0] at);
    path_start = at;
    has_path   = 1'b1;
    mode       = PM_PATH;
  endfunction

  function automatic void path_byte(input logic [CH_W-1:0] c, input logic [OFS_W-1:0] p);
    if (c == CH_QUEST) begin
      path_len    = p - path_start;
      query_start = p + OFS_W'(1);
      has_query   = 1'b1;
      mode        = PM_QUERY;
    end else if (c == CH_HASH) begin
      path_len   = p - path_start;
      frag_start = p + OFS_W'(1);
      has_frag   = 1'b1;
      mode       = PM_FRAG;
    end
  endfunction

  // First byte after a scheme, a byte that rules a scheme out at once, or the byte that ends an authority.
  function automatic void after_scheme(input logic [CH_W-1:0] c, input logic [OFS_W-1:0] p);
    if (c == CH_SLASH) begin
      seg_start = p;
      mode      = PM_SLASH1;
    end else if (c == CH_QUEST) begin
      query_start = p + OFS_W'(1);
      has_query   = 1'b1;
      mode        = PM_QUERY;
    end else if (c == CH_HASH) begin
      frag_start = p + OFS_W'(1);
      has_frag   = 1'b1;
      mode       = PM_FRAG;
    end else begin
      open_path(p);
    end
  endfunction

  function automatic void take_byte(input logic [CH_W-1:0] c, input logic [OFS_W-1:0] p);
    case (mode)
      PM_START: begin
        if (c == CH_HASH) begin
          frag_only  = 1'b1;
          frag_start = OFS_W'(1);
          has_frag   = 1'b1;
          mode       = PM_FRAG;
        end else if (letter_byte(c)) begin
          mode = PM_SCHEME;
        end else begin
          after_scheme(c, p);
        end
      end
      PM_SCHEME: begin
        if (c == CH_COLON) begin
          absolute   = 1'b1;
          scheme_len = p;
          mode       = PM_AFTER_SCHEME;
        end else if (!scheme_byte(c)) begin
          open_path('0);
          path_byte(c, p);
        end
      end
      PM_AFTER_SCHEME: after_scheme(c, p);
      PM_SLASH1: begin
        if (c == CH_SLASH) begin
          host_start = p + OFS_W'(1);
          has_host   = 1'b1;
          mode       = PM_AUTH;
        end else begin
          open_path(seg_start);
          path_byte(c, p);
        end
      end
      PM_AUTH: begin
        if (c == CH_SLASH || c == CH_QUEST || c == CH_HASH) begin
          authority_stop = p;
          after_scheme(c, p);
          if (c == CH_SLASH) open_path(p);
        end else if (c == CH_COLON) begin
          // Only the last colon of the authority splits host from port.
          colon_seen = 1'b1;
          colon_pos  = p;
          port_acc   = '0;
          port_ndig  = '0;
          port_bad   = 1'b0;
        end else if (colon_seen) begin
          if (c < CH_ZERO || c > CH_NINE || port_ndig >= PORT_MAX_DIGITS) begin
            port_bad = 1'b1;
          end else begin
            port_acc  = port_acc * ACC_W'(10) + ACC_W'(c - CH_ZERO);
            port_ndig = port_ndig + DIGIT_W'(1);
          end
        end
      end
      PM_PATH: path_byte(c, p);
      PM_QUERY: begin
        if (c == CH_HASH) begin
          query_len  = p - query_start;
          frag_start = p + OFS_W'(1);
          has_frag   = 1'b1;
          mode       = PM_FRAG;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void due(input ucs_comp_t comp, input logic [OFS_W-1:0] start,
                              input logic [OFS_W-1:0] len, input logic [PORT_W-1:0] port,
                              input logic last);
    recs_due.push_back('{comp, start, len, port, absolute, frag_only, overflowed, last});
  endfunction

  function automatic void close_uri();
    logic [OFS_W-1:0]  host_end;
    logic [PORT_W-1:0] port_num;
    case (mode)
      PM_SCHEME: begin
        open_path('0);
        path_len = pos;
      end
      PM_SLASH1: begin
        open_path(seg_start);
        path_len = pos - seg_start;
      end
      PM_AUTH:  authority_stop = pos;
      PM_PATH:  path_len = pos - path_start;
      PM_QUERY: query_len = pos - query_start;
      default: ;
    endcase
    if (absolute) due(COMP_SCHEME, '0, scheme_len, '0, 1'b0);
    if (has_host) begin
      host_end = colon_seen ? colon_pos : authority_stop;
      due(COMP_HOST, host_start, host_end - host_start, '0, 1'b0);
      if (colon_seen) begin
        port_num = '0;
        if (!port_bad && port_ndig != 0 && port_acc <= 65535) port_num = port_acc[PORT_W-1:0];
        due(COMP_PORT, colon_pos + OFS_W'(1), authority_stop - colon_pos - OFS_W'(1),
            port_num, 1'b0);
      end
    end
    if (has_path) due(COMP_PATH, path_start, path_len, '0, 1'b0);
    if (has_query) due(COMP_QUERY, query_start, query_len, '0, 1'b0);
    if (has_frag) due(COMP_FRAGMENT, frag_start, pos - frag_start, '0, 1'b0);
    due(COMP_CLOSE, '0, pos, '0, 1'b1);
    clear_parse();
  endfunction

  function automatic string rec_text(input record_t r);
    return $sformatf("comp=%0d start=%0d len=%0d port=%0d abs=%0b frag=%0b ovf=%0b last=%0b",
                     r.comp, r.start, r.len, r.port, r.absolute, r.frag_only, r.ovf, r.last);
  endfunction

  always @(posedge clk) begin : watch
    record_t seen, want;
    if (rst) begin
      clear_parse();
      recs_due.delete();
      shown = 0;
      fail_count <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.end_of_uri) begin
          close_uri();
        end else if (pos >= MAX_LEN) begin
          overflowed = 1'b1;
        end else begin
          take_byte(in_ch.ch, pos);
          pos = pos + OFS_W'(1);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        seen = '{ucs_comp_t'(out_ch.component), out_ch.start_offset, out_ch.length,
                 out_ch.port_value, out_ch.abs_flag, out_ch.frag_only_flag,
                 out_ch.overflow, out_ch.last};
        if (recs_due.size() == 0) begin
          fail_count <= fail_count + 1;
          if (shown < SHOW_LIMIT) $display("%0t: record with none expected: %s",
                                           $realtime, rec_text(seen));
          shown++;
        end else begin
          want = recs_due.pop_front();
          if (seen != want) begin
            fail_count <= fail_count + 1;
            if (shown < SHOW_LIMIT) begin
              $display("%0t: record mismatch", $realtime);
              $display("  expected %s", rec_text(want));
              $display("  actual   %s", rec_text(seen));
            end
            shown++;
          end
        end
      end
    end
    pending <= recs_due.size();
  end

endmodule

### dv/tb_uri_component_splitter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uri_component_splitter_top
// Streams URI references into the splitter: a few hand-picked strings, then
// randomly built ones, mostly well-formed with random content plus raw noise.
// Sender gaps and receiver stalls change between phases; the checker beside
// the block predicts every record.
// ----------------------------------------------------------------------------
module tb_uri_component_splitter_top;
  import ucs_pkg::*;

  localparam int QUIET_LIMIT  = 1000;
  localparam int SETTLE_TICKS = 20;
  localparam int PHASE_ITEMS  = 100;

  typedef logic [CH_W-1:0] uri_bytes_t[$];

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   send_gap_pct;
  int   recv_stall_pct;
  int   fail_count;
  int   pending;
  int   quiet;

  ucs_in_if  uri();
  ucs_out_if rec();

  uri_component_splitter_top dut (
    .clk (clk),
    .rst (rst),
    .uri (uri),
    .rec (rec)
  );

  ucs_record_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (uri),
    .out_ch     (rec),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    rec.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Ends the run when neither channel has moved a transfer for too long.
  always @(posedge clk) begin
    if (rst || (uri.valid && uri.ready) || (rec.valid && rec.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [CH_W-1:0] word_char(input bit letters_only);
    string pool;
    pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
    return pool[$urandom_range(letters_only ? 51 : 61)];
  endfunction

  function automatic logic [CH_W-1:0] text_char();
    string marks;
    marks = ":/?#@.-+%=&";
    case ($urandom_range(9))
      0: return marks[$urandom_range(10)];
      1: return CH_W'($urandom_range(255));
      default: return word_char(1'b0);
    endcase
  endfunction

  function automatic void add_str(ref uri_bytes_t q, input string t);
    foreach (t[i]) q.push_back(t[i]);
  endfunction

  function automatic void add_text(ref uri_bytes_t q, input int n);
    repeat (n) q.push_back(text_char());
  endfunction

  function automatic uri_bytes_t make_uri();
    uri_bytes_t q;
    bit         has_auth;
    string      scheme_marks;
    scheme_marks = "+-.";
    has_auth = 1'b0;
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(12)) q.push_back(CH_W'($urandom_range(255)));
      return q;
    end
    if ($urandom_range(99) < 8) begin
      q.push_back(CH_HASH);
      add_text(q, $urandom_range(4));
      return q;
    end
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        q.push_back(word_char(1'b1));
        repeat ($urandom_range(3)) begin
          if ($urandom_range(99) < 75) q.push_back(word_char(1'b0));
          else q.push_back(scheme_marks[$urandom_range(2)]);
        end
        q.push_back(CH_COLON);
      end
      6: begin
        // A scheme may not begin with a digit.
        q.push_back(CH_ZERO + CH_W'($urandom_range(9)));
        q.push_back(word_char(1'b0));
        q.push_back(CH_COLON);
      end
      7: begin
        q.push_back(word_char(1'b1));
        q.push_back(text_char());
        q.push_back(CH_COLON);
      end
      default: ;
    endcase
    if ($urandom_range(99) < 55) begin
      has_auth = 1'b1;
      add_str(q, "//");
      repeat ($urandom_range(5)) begin
        case ($urandom_range(9))
          0: q.push_back(CH_DOT);
          1: q.push_back(CH_COLON);
          default: q.push_back(word_char(1'b0));
        endcase
      end
      if ($urandom_range(99) < 60) begin
        q.push_back(CH_COLON);
        case ($urandom_range(6))
          0: ;
          1: add_str(q, "65535");
          2: add_str(q, "65536");
          3: repeat ($urandom_range(1, 7)) q.push_back(CH_ZERO + CH_W'($urandom_range(9)));
          4: begin
            add_str(q, "8");
            q.push_back(word_char(1'b1));
          end
          default: add_str(q, $sformatf("%0d", $urandom_range(65535)));
        endcase
      end
    end
    if ($urandom_range(99) < 60) begin
      repeat ($urandom_range(1, 3)) begin
        q.push_back(CH_SLASH);
        add_text(q, $urandom_range(3));
      end
    end else if (!has_auth && $urandom_range(99) < 40) begin
      add_text(q, $urandom_range(1, 4));
    end
    if ($urandom_range(99) < 35) begin
      q.push_back(CH_QUEST);
      add_text(q, $urandom_range(4));
    end
    if ($urandom_range(99) < 35) begin
      q.push_back(CH_HASH);
      add_text(q, $urandom_range(4));
    end
    return q;
  endfunction

  task automatic put_item(input logic [CH_W-1:0] c, input logic eou);
    while ($urandom_range(99) < send_gap_pct) begin
      uri.valid <= 1'b0;
      @(posedge clk);
    end
    uri.valid      <= 1'b1;
    uri.ch         <= c;
    uri.end_of_uri <= eou;
    do @(posedge clk); while (!uri.ready);
  endtask

  task automatic send_uri(input uri_bytes_t q);
    foreach (q[i]) put_item(q[i], 1'b0);
    put_item(CH_W'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_text(input string t);
    uri_bytes_t q;
    add_str(q, t);
    send_uri(q);
  endtask

  // Holds the sender off until every expected record has been seen.
  task automatic drain();
    uri.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    uri_bytes_t q;
    int         sent;
    uri.valid      = 1'b0;
    uri.ch         = '0;
    uri.end_of_uri = 1'b0;
    send_gap_pct   = 6;
    recv_stall_pct = 61;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty string, empty fragment-only string, bare scheme, empty host and
    // port, and an out-of-range port with an empty query.
    send_text("");
    send_text("#");
    send_text("a:");
    send_text("x://:");
    send_text("//h:99999?");
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_gap_pct   = (phase == 0) ? 6 : (phase == 1) ? 61 : 0;
      recv_stall_pct = (phase == 0) ? 61 : (phase == 1) ? 6 : 0;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        q = make_uri();
        send_uri(q);
        sent += q.size() + 1;
      end
      drain();
    end

    repeat (SETTLE_TICKS) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
